### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

### hw/rtl/tlbpt_pkg.sv
// ---------------------------------------------------------------------------
// tlbpt_pkg
// shared types and constants of the page translator
// ---------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int HIT_CNT_W = 32;
  localparam logic [HIT_CNT_W-1:0] HIT_CNT_MAX = '1;

  typedef struct packed {
    logic page_fault;
    logic tlb_hit;
  } out_flags_t;

endpackage

### hw/rtl/tlb_lru_page_translator.sv
// ---------------------------------------------------------------------------
// tlb_lru_page_translator
// logical to physical address translation, fully associative tlb with lru
// ---------------------------------------------------------------------------
// One translation per cycle sustained while the output is not stalled. An
// accepted transaction is held in the stage-1 register and its result in the
// output register. The page table frame memory is read when a transaction is
// accepted (with a bypass from the write of the transaction just ahead); the
// tag compare, lru rank update, page fault allocation and counter updates all
// happen together as it leaves stage 1. Page-mapped flags are flip-flops
// cleared by reset, so no clearing pass is needed after reset. The hit count
// saturates at all ones; frames are handed out in order and never reused.
module tlb_lru_page_translator #(
  parameter int PAGE_BITS   = 8,
  parameter int OFFSET_BITS = 8,
  parameter int TLB_ENTRIES = 16,
  localparam int ADDR_W      = PAGE_BITS + OFFSET_BITS,
  localparam int FCNT_W      = PAGE_BITS + 1,
  localparam int IN_TDATA_W  = ((ADDR_W + 7) / 8) * 8,
  localparam int OUT_BITS    = ADDR_W + PAGE_BITS + tlbpt_pkg::HIT_CNT_W + FCNT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // logical_address
  input  logic [IN_TDATA_W-1:0]    in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // physical_address, frame_number, hit_count, fault_count
  output logic [OUT_TDATA_W-1:0]   out_tdata,
  // tlb_hit, page_fault
  output tlbpt_pkg::out_flags_t    out_tuser
);

  import tlbpt_pkg::*;

  localparam int NUM_PAGES  = 1 << PAGE_BITS;
  localparam int IDX_W      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [IDX_W-1:0]  TOP_RANK   = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [FCNT_W-1:0] FRAME_LAST = FCNT_W'(NUM_PAGES);

  // pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance, in_accept, proc;

  logic [ADDR_W-1:0]      s1_addr_r;
  logic [PAGE_BITS-1:0]   in_page, page;
  logic [OFFSET_BITS-1:0] offset;

  // page table
  logic [PAGE_BITS-1:0] pt_mem [NUM_PAGES];
  logic [PAGE_BITS-1:0] pt_rd_r;
  logic                 byp_r;
  logic [PAGE_BITS-1:0] byp_data_r;
  logic [PAGE_BITS-1:0] pt_frame;
  logic                 pt_write;
  logic [NUM_PAGES-1:0] mapped_r, mapped_nxt;

  // tlb
  logic [TLB_ENTRIES-1:0] valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]   tag_r   [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   frame_r [TLB_ENTRIES];
  logic [IDX_W-1:0]       rank_r  [TLB_ENTRIES];
  logic [IDX_W-1:0]       rank_nxt[TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] hit_vec, top_vec;

  logic                 hit, fault;
  logic [IDX_W-1:0]     hit_idx, free_idx, lru_idx, slot_idx, touch_idx;
  logic [IDX_W-1:0]     old_rank;
  logic                 any_free;
  logic [PAGE_BITS-1:0] frame;

  // counters
  logic [FCNT_W-1:0]    next_free_r, next_free_nxt;
  logic [HIT_CNT_W-1:0] hits_r, hits_nxt;
  logic [FCNT_W-1:0]    faults_r, faults_nxt;

  // result register
  logic [ADDR_W-1:0]    out_phys_r;
  logic [PAGE_BITS-1:0] out_frame_r;
  out_flags_t           out_flags_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;
  assign proc      = s1_valid_r && advance;

  assign in_page = in_tdata[ADDR_W-1:OFFSET_BITS];
  assign page    = s1_addr_r[ADDR_W-1:OFFSET_BITS];
  assign offset  = s1_addr_r[OFFSET_BITS-1:0];

  assign pt_frame = byp_r ? byp_data_r : pt_rd_r;

  // tag compare and entry selection
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    any_free = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == page);
      top_vec[i] = (rank_r[i] == TOP_RANK);
    end
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
      if (rank_r[i] == '0) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |hit_vec;
  assign fault     = !hit && !mapped_r[page];
  assign slot_idx  = any_free ? free_idx : lru_idx;
  assign touch_idx = hit ? hit_idx : slot_idx;
  assign old_rank  = rank_r[touch_idx];
  assign pt_write  = proc && fault;

  always_comb begin
    priority if (hit) begin
      frame = frame_r[hit_idx];
    end else if (mapped_r[page]) begin
      frame = pt_frame;
    end else begin
      frame = next_free_r[PAGE_BITS-1:0];
    end
  end

  // state next values
  always_comb begin
    valid_nxt     = valid_r;
    mapped_nxt    = mapped_r;
    next_free_nxt = next_free_r;
    hits_nxt      = hits_r;
    faults_nxt    = faults_r;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (proc) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (IDX_W'(i) == touch_idx) begin
          rank_nxt[i] = TOP_RANK;
        end else if (rank_r[i] > old_rank) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
      if (hit) begin
        if (hits_r != HIT_CNT_MAX) begin
          hits_nxt = hits_r + 1'b1;
        end
      end else begin
        valid_nxt[slot_idx] = 1'b1;
      end
      if (fault) begin
        mapped_nxt[page] = 1'b1;
        faults_nxt       = faults_r + 1'b1;
        if (next_free_r < FRAME_LAST) begin
          next_free_nxt = next_free_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      mapped_r    <= '0;
      next_free_r <= '0;
      hits_r      <= '0;
      faults_r    <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      mapped_r    <= mapped_nxt;
      next_free_r <= next_free_nxt;
      hits_r      <= hits_nxt;
      faults_r    <= faults_nxt;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= in_tdata[ADDR_W-1:0];
    end
    if (proc && !hit) begin
      tag_r[slot_idx]   <= page;
      frame_r[slot_idx] <= frame;
    end
    if (proc) begin
      out_phys_r             <= {frame, offset};
      out_frame_r            <= frame;
      out_flags_r.tlb_hit    <= hit;
      out_flags_r.page_fault <= fault;
    end
  end

  // page table frame memory
  always_ff @(posedge clk) begin
    if (pt_write) begin
      pt_mem[page] <= next_free_r[PAGE_BITS-1:0];
    end
    if (in_accept) begin
      pt_rd_r    <= pt_mem[in_page];
      byp_r      <= pt_write && (page == in_page);
      byp_data_r <= next_free_r[PAGE_BITS-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_flags_r;
  assign out_tdata  = OUT_TDATA_W'({faults_r, hits_r, out_frame_r, out_phys_r});

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_top_rank_unique, clk, rst_n, $onehot(top_vec))
  `ASSERT_IMPLY(a_hit_is_mapped, clk, rst_n, s1_valid_r && hit, mapped_r[page])
  `ASSERT_NEXT(a_touched_is_top, clk, rst_n, proc, rank_r[$past(touch_idx)] == TOP_RANK)
  `ASSERT_NEXT(a_fault_allocates, clk, rst_n, proc && fault,
               faults_r == $past(faults_r) + 1'b1)

endmodule

### dv/tlb_lru_page_translator_tb.sv
// ---------------------------------------------------------------------------
// tlb_lru_page_translator_tb
// self-checking stream testbench for the tlb address translator: a queue fed
// driver offers logical addresses with random gaps, a model of the tlb, lru
// ranks and page table predicts every translation, and a monitor compares
// each output transaction field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tlb_lru_page_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlbpt_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int PAGES       = 256;
  localparam int STIM_ITEMS  = 1575;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 500;
  localparam int DRAIN_WAIT  = 10;

  typedef struct {
    logic [15:0] phys;
    logic [7:0]  frame;
    logic        hit;
    logic        fault;
    logic [31:0] hits;
    logic [8:0]  faults;
  } xlat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  out_flags_t  out_tuser;

  tlb_lru_page_translator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // translation model state
  bit          tlb_valid [ENTRIES];
  logic [7:0]  tlb_tag   [ENTRIES];
  logic [7:0]  tlb_frame [ENTRIES];
  logic [3:0]  lru_rank  [ENTRIES];
  bit          pt_mapped [PAGES];
  logic [7:0]  pt_frame  [PAGES];
  int          free_frame;
  logic [31:0] hit_total;
  logic [8:0]  fault_total;

  logic [15:0] addr_q [$];
  xlat_t       xlat_q [$];
  int          err_cnt = 0;
  int          in_cnt = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          send_gap = 0;
  int          send_calm = 0;
  int          rcv_gap = 0;
  int          rcv_calm = 0;
  bit          held_off = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tlb_valid[i] = 0;
      tlb_tag[i]   = '0;
      tlb_frame[i] = '0;
      lru_rank[i]  = 4'(i);
    end
    for (int p = 0; p < PAGES; p++) begin
      pt_mapped[p] = 0;
      pt_frame[p]  = '0;
    end
    free_frame  = 0;
    hit_total   = '0;
    fault_total = '0;
  end

  function automatic void touch_entry(int e);
    logic [3:0] old;
    old = lru_rank[e];
    for (int i = 0; i < ENTRIES; i++) begin
      if (lru_rank[i] > old) lru_rank[i] = lru_rank[i] - 4'd1;
    end
    lru_rank[e] = 4'(ENTRIES - 1);
  endfunction

  function automatic xlat_t translate(logic [15:0] la);
    xlat_t      r;
    logic [7:0] pg;
    logic [7:0] frm;
    int         slot;
    r.hit   = 1'b0;
    r.fault = 1'b0;
    pg      = la[15:8];
    frm     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tlb_valid[i] && tlb_tag[i] == pg) begin
        r.hit = 1'b1;
        frm   = tlb_frame[i];
        touch_entry(i);
        if (hit_total != HIT_CNT_MAX) hit_total = hit_total + 32'd1;
        break;
      end
    end
    if (!r.hit) begin
      if (pt_mapped[pg]) begin
        frm = pt_frame[pg];
      end else begin
        r.fault = 1'b1;
        frm     = 8'(free_frame);
        if (free_frame < PAGES) free_frame++;
        if (fault_total != 9'h1FF) fault_total = fault_total + 9'd1;
        pt_mapped[pg] = 1;
        pt_frame[pg]  = frm;
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!tlb_valid[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        slot = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (lru_rank[i] == 4'd0) begin
            slot = i;
            break;
          end
        end
      end
      tlb_valid[slot] = 1;
      tlb_tag[slot]   = pg;
      tlb_frame[slot] = frm;
      touch_entry(slot);
    end
    r.frame  = frm;
    r.phys   = {frm, la[7:0]};
    r.hits   = hit_total;
    r.faults = fault_total;
    return r;
  endfunction

  function automatic int next_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      err_cnt++;
    end
  endfunction

  task automatic push(input logic [7:0] pg, input logic [7:0] off);
    addr_q.push_back({pg, off});
  endtask

  // input side: predict on every accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      xlat_q.push_back(translate(in_tdata));
      void'(addr_q.pop_front());
      in_cnt++;
    end
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_fire)) begin
      if (in_fire) send_gap = next_gap(send_calm);
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (addr_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= addr_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output side: random backpressure plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!held_off && in_cnt >= HOLD_AFTER) begin
        held_off = 1;
        rcv_gap  = HOLD_CYCLES;
      end else if (out_fire) begin
        rcv_gap = next_gap(rcv_calm);
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    xlat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (xlat_q.size() == 0) begin
        $error("output transaction with no translation pending: tdata 0x%0h", out_tdata);
        err_cnt++;
      end else begin
        e = xlat_q.pop_front();
        check_field("physical_address", 32'(e.phys),   32'(out_tdata[15:0]));
        check_field("frame_number",     32'(e.frame),  32'(out_tdata[23:16]));
        check_field("hit_count",        e.hits,        out_tdata[55:24]);
        check_field("fault_count",      32'(e.faults), 32'(out_tdata[64:56]));
        check_field("tlb_hit",          32'(e.hit),    32'(out_tuser.tlb_hit));
        check_field("page_fault",       32'(e.fault),  32'(out_tuser.page_fault));
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("** tlb_lru_page_translator: FAILED **");
    $finish;
  end

  initial begin
    int         kind;
    int         len;
    int         n;
    int         rounds;
    logic [7:0] ws [20];
    logic [7:0] sweep_ptr;

    // directed: address extremes, hits, tlb fill, lru eviction, table hit
    push(8'h00, 8'h00);
    push(8'hFF, 8'hFF);
    push(8'h00, 8'hFF);
    push(8'hFF, 8'h00);
    push(8'h5A, 8'hA5);
    push(8'hA5, 8'h5A);
    for (int i = 0; i < 12; i++) push(8'h10 + 8'(i), 8'($urandom));
    push(8'h00, 8'h80);
    push(8'h1C, 8'h01);
    push(8'hFF, 8'h7F);
    push(8'h5A, 8'h00);
    push(8'hA5, 8'hFE);

    sweep_ptr = 8'($urandom);
    while (addr_q.size() < STIM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // working set with locality
        n   = $urandom_range(1, 20);
        len = $urandom_range(20, 60);
        for (int i = 0; i < n; i++) ws[i] = 8'($urandom);
        for (int i = 0; i < len; i++) push(ws[$urandom_range(0, n - 1)], 8'($urandom));
      end else if (kind <= 5) begin
        // sweep of consecutive pages
        len = $urandom_range(8, 40);
        for (int i = 0; i < len; i++) begin
          push(sweep_ptr, 8'($urandom));
          sweep_ptr = sweep_ptr + 8'd1;
        end
      end else if (kind <= 7) begin
        // cyclic pattern around the tlb size
        n      = $urandom_range(ENTRIES - 1, ENTRIES + 2);
        rounds = $urandom_range(2, 4);
        for (int i = 0; i < n; i++) ws[i] = 8'($urandom);
        for (int r = 0; r < rounds; r++) begin
          for (int i = 0; i < n; i++) push(ws[i], 8'($urandom));
        end
      end else begin
        len = $urandom_range(5, 20);
        for (int i = 0; i < len; i++) push(8'($urandom), 8'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (addr_q.size() != 0 || xlat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (xlat_q.size() != 0) begin
      $error("%0d translations never came out", xlat_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** tlb_lru_page_translator: PASSED **");
    end else begin
      $display("** tlb_lru_page_translator: FAILED **");
    end
    $finish;
  end

endmodule
